FILE: rtl/afr_pkg.sv
// Package with the types, register indexes and round functions of the AES first round block.
`default_nettype none

package afr_pkg;

   // The 128-bit state is {high half, low half}. Byte n sits at bits 127-8n down to 120-8n.
   typedef logic [127:0] afr_state_type;
   typedef logic [7:0]   afr_byte_type;
   typedef logic [63:0]  afr_word_type;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   typedef logic [CSR_INDEX_WIDTH-1:0] afr_csr_index_type;

   localparam afr_csr_index_type CSR_KEY_HIGH = 1'b0;
   localparam afr_csr_index_type CSR_KEY_LOW  = 1'b1;

   localparam afr_byte_type GF_REDUCE = 8'h1b;

   localparam afr_byte_type SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Multiplication by two in GF(2^8) with the AES polynomial.
   function automatic afr_byte_type gf_double(input afr_byte_type v);
      gf_double = {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
   endfunction

   // SubBytes on all sixteen bytes.
   function automatic afr_state_type sub_bytes(input afr_state_type s);
      afr_state_type r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[127-8*n -: 8] = SBOX_TABLE[s[127-8*n -: 8]];
      end
      return r;
   endfunction

   // ShiftRows followed by MixColumns, one column at a time.
   function automatic afr_state_type shift_mix(input afr_state_type s);
      afr_state_type r;
      afr_byte_type  a [4];
      afr_byte_type  d [4];
      logic [1:0]    src_col;
      r = '0;
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            src_col = 2'(col + row);
            a[row]  = s[127-8*(4*int'(src_col)+row) -: 8];
            d[row]  = gf_double(a[row]);
         end
         r[127-8*(4*col)   -: 8] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
         r[127-8*(4*col+1) -: 8] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
         r[127-8*(4*col+2) -: 8] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
         r[127-8*(4*col+3) -: 8] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/afr_req_if.sv
// Interface of the request channel that carries one plaintext block.
`default_nettype none

interface afr_req_if;
   logic                 valid;
   logic                 ready;
   afr_pkg::afr_word_type block_high;
   afr_pkg::afr_word_type block_low;

   modport source (output valid, output block_high, output block_low, input ready);
   modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

`default_nettype wire

FILE: rtl/afr_rsp_if.sv
// Interface of the response channel that carries one round result.
`default_nettype none

interface afr_rsp_if;
   logic                 valid;
   logic                 ready;
   afr_pkg::afr_word_type round_high;
   afr_pkg::afr_word_type round_low;

   modport source (output valid, output round_high, output round_low, input ready);
   modport sink   (input valid, input round_high, input round_low, output ready);
endinterface

`default_nettype wire

FILE: rtl/aes_first_round_top.sv
// Top level of the AES first round block: key add, SubBytes, ShiftRows and MixColumns.
`default_nettype none

//  Channel   Direction  Payload                      Handshake
//  req_chan  in         block_high, block_low        valid / ready
//  rsp_chan  out        round_high, round_low        valid / ready
//  csr_*     in         csr_index, csr_data (64 b)   csr_write, no back-pressure
//
// A request passes three register stages: key add, S-box and ShiftRows/MixColumns.
// Its response becomes valid when it reaches stage 3 and is held there until taken.
// While the response side is ready, a new request can be accepted in every cycle, so
// the sustained rate is one block per clock.
// Synchronous active-high reset clears the stage valid bits and both key registers.
// When the response is stalled, each stage holds unless the one after it is empty or
// moving, so bubbles are squeezed out and no request is dropped or repeated.
module aes_first_round_top (
   input  wire                          clock,
   input  wire                          reset,
   afr_req_if.sink                      req_chan,
   afr_rsp_if.source                    rsp_chan,
   input  wire                          csr_write,
   input  wire afr_pkg::afr_csr_index_type csr_index,
   input  wire afr_pkg::afr_word_type   csr_data
);
   import afr_pkg::*;

   // Round keys. The user must change them only while the pipeline is empty; unchecked.
   afr_word_type key_high_ff, key_high_in;
   afr_word_type key_low_ff,  key_low_in;

   // Stage 1 holds the state after the key add, stage 2 after SubBytes and
   // stage 3 the finished round result that drives the response channel.
   logic          valid1_ff, valid1_in;
   logic          valid2_ff, valid2_in;
   logic          valid3_ff, valid3_in;
   afr_state_type data1_ff,  data1_in;
   afr_state_type data2_ff,  data2_in;
   afr_state_type data3_ff,  data3_in;

   logic advance1, advance2, advance3;

   // A stage may load when it is empty or when its content moves on this cycle.
   assign advance3 = !valid3_ff || rsp_chan.ready;
   assign advance2 = !valid2_ff || advance3;
   assign advance1 = !valid1_ff || advance2;

   assign req_chan.ready = advance1;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_data;
            CSR_KEY_LOW:  key_low_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      valid1_in = valid1_ff;
      data1_in  = data1_ff;
      if (advance1) begin
         valid1_in = req_chan.valid;
         data1_in  = {req_chan.block_high, req_chan.block_low} ^ {key_high_ff, key_low_ff};
      end

      valid2_in = valid2_ff;
      data2_in  = data2_ff;
      if (advance2) begin
         valid2_in = valid1_ff;
         data2_in  = sub_bytes(data1_ff);
      end

      valid3_in = valid3_ff;
      data3_in  = data3_ff;
      if (advance3) begin
         valid3_in = valid2_ff;
         data3_in  = shift_mix(data2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         valid1_ff   <= 1'b0;
         valid2_ff   <= 1'b0;
         valid3_ff   <= 1'b0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         valid1_ff   <= valid1_in;
         valid2_ff   <= valid2_in;
         valid3_ff   <= valid3_in;
      end
   end

   // The data registers carry no reset; their valid bits qualify them.
   always_ff @(posedge clock) begin
      data1_ff <= data1_in;
      data2_ff <= data2_in;
      data3_ff <= data3_in;
   end

   assign rsp_chan.valid      = valid3_ff;
   assign rsp_chan.round_high = data3_ff[127:64];
   assign rsp_chan.round_low  = data3_ff[63:0];

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the AES first round block with random stalls on both channels.
`timescale 1ns / 100ps

module tb;
   import afr_pkg::*;

   // Pipeline depth given at the head of the top level.
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 242;
   localparam int HOLD_CYCLES = 80;

   // The scoreboard keeps its own copy of the key, predicts one round per accepted
   // request and compares each response with the oldest prediction still waiting.
   class round_tracker;
      afr_word_type     key_high;
      afr_word_type     key_low;
      logic [127:0]     expected_rounds[$];
      int               errors;
      int               requests;
      int               responses;

      function new();
         key_high  = '0;
         key_low   = '0;
         errors    = 0;
         requests  = 0;
         responses = 0;
      endfunction

      function void set_key(afr_csr_index_type index, afr_word_type value);
         if (index == CSR_KEY_HIGH)
            key_high = value;
         else if (index == CSR_KEY_LOW)
            key_low = value;
      endfunction

      function afr_byte_type times_two(afr_byte_type v);
         return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
      endfunction

      // Key add, SubBytes, ShiftRows and MixColumns on a column-major state.
      function logic [127:0] compute_round(afr_word_type hi, afr_word_type lo);
         logic [127:0] mixed;
         logic [127:0] keyed;
         afr_byte_type subbed [16];
         afr_byte_type shifted [16];
         afr_byte_type a [4];
         afr_byte_type d [4];
         keyed = {hi, lo} ^ {key_high, key_low};
         for (int n = 0; n < 16; n++)
            subbed[n] = SBOX_TABLE[keyed[127-8*n -: 8]];
         // Row r of the state moves left by r columns.
         for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++)
               shifted[col*4+row] = subbed[((col + row) % 4)*4 + row];
         for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
               a[row] = shifted[col*4+row];
               d[row] = times_two(a[row]);
            end
            mixed[127-8*(4*col)   -: 8] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
            mixed[127-8*(4*col+1) -: 8] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
            mixed[127-8*(4*col+2) -: 8] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
            mixed[127-8*(4*col+3) -: 8] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
         end
         return mixed;
      endfunction

      function void note_block(afr_word_type hi, afr_word_type lo);
         expected_rounds.push_back(compute_round(hi, lo));
         requests++;
      endfunction

      function void check_round(afr_word_type hi, afr_word_type lo);
         logic [127:0] want;
         responses++;
         if (expected_rounds.size() == 0) begin
            $error("response with no request outstanding: round_high %h round_low %h", hi, lo);
            errors++;
         end else begin
            want = expected_rounds.pop_front();
            if (hi !== want[127:64]) begin
               $error("round_high: expected %h, actual %h", want[127:64], hi);
               errors++;
            end
            if (lo !== want[63:0]) begin
               $error("round_low: expected %h, actual %h", want[63:0], lo);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_rounds.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_write;
   afr_csr_index_type  csr_index;
   afr_word_type       csr_data;

   afr_req_if req_chan ();
   afr_rsp_if rsp_chan ();

   aes_first_round_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   round_tracker tracker = new();

   // Percent chances of an idle burst on each side; both are set per phase.
   int  gap_pct   = 0;
   int  stall_pct = 0;
   // Raised by the stimulus to ask the response side for one long hold-off.
   bit  long_hold = 0;
   int  cycle_count = 0;
   int  key_writes  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs, for instance on a lost response.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, tracker.pending());
         $display("tb failed");
         $finish;
      end
   end

   // Both channels are watched at the clock edge. The request is noted before the
   // response is checked so that a combinational design would still be judged fairly.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tracker.note_block(req_chan.block_high, req_chan.block_low);
         if (rsp_chan.valid && rsp_chan.ready)
            tracker.check_round(rsp_chan.round_high, rsp_chan.round_low);
      end
   end

   // The response side stalls in random bursts, and once holds off for a long
   // stretch so that the pipeline fills up and the request side backs up.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 0;
         end else if ($urandom_range(1, 100) <= stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // A word with a mix of shapes: fully random, one byte repeated, or one byte set.
   function automatic afr_word_type random_word();
      afr_word_type w;
      afr_byte_type b;
      b = afr_byte_type'($urandom);
      w = '0;
      case ($urandom_range(0, 3))
         0, 1: w = {$urandom, $urandom};
         2: w = {8{b}};
         default: w[8*$urandom_range(0, 7) +: 8] = b;
      endcase
      return w;
   endfunction

   // Offers one request and returns at the edge where it was accepted. Valid stays
   // high so that a following call can present the next block without a bubble.
   task automatic send_block(afr_word_type hi, afr_word_type lo);
      req_chan.valid      <= 1'b1;
      req_chan.block_high <= hi;
      req_chan.block_low  <= lo;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_burst(int cycles);
      req_chan.valid      <= 1'b0;
      req_chan.block_high <= {$urandom, $urandom};
      req_chan.block_low  <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted round has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // The key may only change while nothing is in flight, so callers drain first.
   task automatic write_key(afr_csr_index_type index, afr_word_type value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      tracker.set_key(index, value);
      key_writes++;
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      afr_word_type phase_key_high [PHASES];
      afr_word_type phase_key_low [PHASES];
      int           phase_gap [PHASES];
      int           phase_stall [PHASES];

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.block_high <= '0;
      req_chan.block_low  <= '0;
      csr_write           <= 1'b0;
      csr_index           <= CSR_KEY_HIGH;
      csr_data            <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The predictor is first checked against the published first-round vector.
      tracker.key_high = 64'h2b7e151628aed2a6;
      tracker.key_low  = 64'habf7158809cf4f3c;
      if (tracker.compute_round(64'h3243f6a8885a308d, 64'h313198a2e0370734)
          !== 128'h046681e5e0cb199a48f8d37a2806264c) begin
         $error("predictor disagrees with the published first-round vector");
         tracker.errors++;
      end
      tracker.key_high = '0;
      tracker.key_low  = '0;

      // Directed part with the key still at its reset value of zero: field extremes,
      // alternating bits, bytes with the top bit set so that xtime must reduce, and
      // single bits at both ends of the state, and a counting byte sequence.
      stall_pct = 0;
      send_block('0, '0);
      send_block('1, '1);
      send_block({16{4'ha}}, {16{4'h5}});
      send_block({8{8'h80}}, {8{8'h01}});
      send_block(64'h8000000000000000, 64'h0000000000000001);
      send_block(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      wait_drained();

      // Only the upper key half set, then both halves at their maximum.
      write_key(CSR_KEY_HIGH, '1);
      send_block('0, '0);
      send_block('1, '1);
      wait_drained();
      write_key(CSR_KEY_LOW, '1);
      send_block('0, '0);
      send_block('1, '0);
      wait_drained();

      // The published vector, sent through the block itself.
      write_key(CSR_KEY_HIGH, 64'h2b7e151628aed2a6);
      write_key(CSR_KEY_LOW, 64'habf7158809cf4f3c);
      send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_block(64'h00112233445566ff, 64'h8899aabbccddee77);
      wait_drained();

      // Random part. Each phase has its own key and its own mix of idling; the last
      // phase runs with both sides busy all the time.
      phase_key_high = '{{$urandom, $urandom}, '0, {$urandom, $urandom}, '1, '0,
                         {$urandom, $urandom}};
      phase_key_low  = '{{$urandom, $urandom}, '1, {$urandom, $urandom}, '1, '0,
                         {$urandom, $urandom}};
      phase_gap      = '{20, 0, 10, 30, 25, 0};
      phase_stall    = '{20, 30, 10, 0, 25, 0};

      for (int phase = 0; phase < PHASES; phase++) begin
         write_key(CSR_KEY_HIGH, phase_key_high[phase]);
         write_key(CSR_KEY_LOW, phase_key_low[phase]);
         gap_pct   = phase_gap[phase];
         stall_pct = phase_stall[phase];
         // In the third phase the response side holds off while requests keep coming.
         if (phase == 2)
            long_hold = 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Halfway through the fourth phase the request side pauses until the
            // pipeline has emptied completely.
            if (phase == 3 && i == PHASE_ITEMS / 2)
               wait_drained();
            else if ($urandom_range(1, 100) <= gap_pct)
               idle_burst($urandom_range(1, 8));
            send_block(random_word(), random_word());
         end
         wait_drained();
      end

      // Let any stray response show up before the verdict.
      repeat (4 * LATENCY) @(posedge clock);

      $display("Ran %0d requests and %0d responses over %0d key writes,", tracker.requests,
               tracker.responses, key_writes);
      $display("with random stalls on both sides, a long response hold-off and a drained pause.");
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
